@@ rtl/sh2x_pkg.sv @@
`default_nettype none
package sh2x_pkg;

  localparam int unsigned NumRegs  = 16;
  localparam int unsigned OpW      = 6;
  localparam logic [31:0] SignBit  = 32'h8000_0000;
  localparam logic [31:0] PcStep   = 32'd2;

  typedef enum logic [5:0] {
    OP_SHAR    = 6'd0,  OP_BTS     = 6'd1,  OP_BFS     = 6'd2,  OP_EXTUB   = 6'd3,
    OP_EXTUW   = 6'd4,  OP_EXTSB   = 6'd5,  OP_EXTSW   = 6'd6,  OP_CMPPZ   = 6'd7,
    OP_CMPPL   = 6'd8,  OP_MOVW_PI = 6'd9,  OP_AND     = 6'd10, OP_OR      = 6'd11,
    OP_CMPHS   = 6'd12, OP_CMPGE   = 6'd13, OP_CMPHI   = 6'd14, OP_CMPGT   = 6'd15,
    OP_ROTCL   = 6'd16, OP_ANDI    = 6'd17, OP_TSTI    = 6'd18, OP_LDB_D   = 6'd19,
    OP_STB_D   = 6'd20, OP_LDW_R0  = 6'd21, OP_LDL_R0  = 6'd22, OP_LDB_R0  = 6'd23,
    OP_STL_R0  = 6'd24, OP_STW_R0  = 6'd25, OP_STB_R0  = 6'd26, OP_SHLL8   = 6'd27,
    OP_SHLL16  = 6'd28, OP_SHLR8   = 6'd29, OP_SHLR16  = 6'd30, OP_DT      = 6'd31,
    OP_MOVT    = 6'd32
  } op_t;

  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindRead  = 2'd1;
  localparam logic [1:0] KindWrite = 2'd2;
  localparam logic [1:0] SizeByte  = 2'd0;
  localparam logic [1:0] SizeWord  = 2'd1;
  localparam logic [1:0] SizeLong  = 2'd2;

  // classified word handed from front to back
  typedef struct packed {
    logic        mode;
    logic        known;
    logic [5:0]  opcode;
    logic [3:0]  reg_n;
    logic [3:0]  reg_m;
    logic [7:0]  displacement;
    logic [31:0] branch_target;
    logic [31:0] load_data;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [31:0] next_pc;
    logic        t_flag;
    logic [1:0]  mem_kind;
    logic [1:0]  mem_size;
    logic [31:0] mem_address;
    logic [31:0] mem_write_data;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/sh2x_front.sv @@
`default_nettype none
module sh2x_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_mode,
  input  wire logic [5:0]    in_opcode,
  input  wire logic [3:0]    in_reg_n,
  input  wire logic [3:0]    in_reg_m,
  input  wire logic [7:0]    in_displacement,
  input  wire logic [31:0]   in_branch_target,
  input  wire logic [31:0]   in_load_data,
  output logic               q_valid,
  input  wire logic          q_ready,
  output sh2x_pkg::cmd_t     q_cmd
);
  import sh2x_pkg::*;

  // two-entry queue
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       c;
  logic       push, pop;

  always_comb begin
    c.mode          = in_mode;
    c.known         = (in_opcode <= 6'(OP_MOVT));
    c.opcode        = in_opcode;
    c.reg_n         = in_reg_n;
    c.reg_m         = in_reg_m;
    c.displacement  = in_displacement;
    c.branch_target = in_branch_target;
    c.load_data     = in_load_data;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

@@ rtl/sh2x_back.sv @@
`default_nettype none
module sh2x_back #(
  parameter int unsigned NUM_REGS = sh2x_pkg::NumRegs
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [31:0]   start_pc,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire sh2x_pkg::cmd_t q_cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sh2x_pkg::res_t     out_res
);
  import sh2x_pkg::*;
  localparam int unsigned RW = $clog2(NUM_REGS);

  logic [31:0] rf_r [NUM_REGS];
  logic [31:0] pc_r;
  logic        t_r;
  logic        lp_r;
  logic [RW-1:0] ld_r;
  logic [1:0]  lw_r;
  logic        ov_r;
  res_t        res_r;

  logic [31:0] rn, rm, r0, d32, wval, lv;
  logic [RW-1:0] wi, ni, mi;
  logic        we, t_nxt, adv, st;
  logic        lset;
  logic [1:0]  kind, size, lw_nxt;
  logic [31:0] addr, wdata;
  logic [RW-1:0] ld_nxt;
  logic        fire;
  logic [32:0] dif;

  assign q_ready = !ov_r || out_ready;
  assign fire    = q_valid && q_ready;
  assign ni  = q_cmd.reg_n[RW-1:0];
  assign mi  = q_cmd.reg_m[RW-1:0];
  assign rn  = rf_r[ni];
  assign rm  = rf_r[mi];
  assign r0  = rf_r[0];
  assign d32 = {24'd0, q_cmd.displacement};
  assign dif = {1'b0, rn} - {1'b0, rm};

  always_comb begin
    we = 1'b0; wi = ni; wval = '0; t_nxt = t_r; adv = 1'b1; st = 1'b0;
    kind = KindNone; size = SizeByte; addr = '0; wdata = '0;
    lset = 1'b0; ld_nxt = ni; lw_nxt = SizeByte; lv = q_cmd.load_data;
    case (lw_r)
      SizeByte: lv = {{24{q_cmd.load_data[7]}}, q_cmd.load_data[7:0]};
      SizeWord: lv = {{16{q_cmd.load_data[15]}}, q_cmd.load_data[15:0]};
      default:  lv = q_cmd.load_data;
    endcase
    if (q_cmd.mode) begin
      adv = 1'b0;
      if (lp_r) begin we = 1'b1; wi = ld_r; wval = lv; end
    end else if (!q_cmd.known) begin
      st = 1'b1; adv = 1'b0;
    end else begin
      case (op_t'(q_cmd.opcode))
        OP_SHAR:  begin t_nxt = rn[0]; we = 1'b1; wval = {rn[31], rn[31:1]}; end
        OP_BTS:   adv = !t_r;
        OP_BFS:   adv = t_r;
        OP_EXTUB: begin we = 1'b1; wval = {24'd0, rm[7:0]}; end
        OP_EXTUW: begin we = 1'b1; wval = {16'd0, rm[15:0]}; end
        OP_EXTSB: begin we = 1'b1; wval = {{24{rm[7]}}, rm[7:0]}; end
        OP_EXTSW: begin we = 1'b1; wval = {{16{rm[15]}}, rm[15:0]}; end
        OP_CMPPZ: t_nxt = !rn[31];
        OP_CMPPL: t_nxt = !rn[31] && (rn != '0);
        OP_MOVW_PI: begin
          kind = KindRead; size = SizeWord; addr = rm;
          we = 1'b1; wi = mi; wval = rm + PcStep;
          lset = 1'b1; lw_nxt = SizeWord;
        end
        OP_AND:   begin we = 1'b1; wval = rn & rm; end
        OP_OR:    begin we = 1'b1; wval = rn | rm; end
        OP_CMPHS: t_nxt = !dif[32];
        OP_CMPGE: t_nxt = (rn[31] != rm[31]) ? !rn[31] : !dif[32];
        OP_CMPHI: t_nxt = !dif[32] && (rn != rm);
        OP_CMPGT: t_nxt = (rn[31] != rm[31]) ? !rn[31] : (!dif[32] && (rn != rm));
        OP_ROTCL: begin we = 1'b1; wval = {rn[30:0], t_r}; t_nxt = rn[31]; end
        OP_ANDI:  begin we = 1'b1; wi = '0; wval = r0 & d32; end
        OP_TSTI:  t_nxt = ((r0 & d32) == '0);
        OP_LDB_D: begin
          kind = KindRead; size = SizeByte; addr = rm + d32;
          lset = 1'b1; ld_nxt = '0; lw_nxt = SizeByte;
        end
        OP_STB_D: begin
          kind = KindWrite; size = SizeByte; addr = rn + d32; wdata = {24'd0, r0[7:0]};
        end
        OP_LDW_R0, OP_LDL_R0, OP_LDB_R0: begin
          kind = KindRead; addr = rm + r0; lset = 1'b1;
          size = (q_cmd.opcode == 6'(OP_LDW_R0)) ? SizeWord :
                 (q_cmd.opcode == 6'(OP_LDL_R0)) ? SizeLong : SizeByte;
          lw_nxt = size;
        end
        OP_STL_R0: begin kind = KindWrite; size = SizeLong; addr = rn + r0; wdata = rm; end
        OP_STW_R0: begin
          kind = KindWrite; size = SizeWord; addr = rn + r0; wdata = {16'd0, rm[15:0]};
        end
        OP_STB_R0: begin
          kind = KindWrite; size = SizeByte; addr = rn + r0; wdata = {24'd0, rm[7:0]};
        end
        OP_SHLL8:  begin we = 1'b1; wval = {rn[23:0], 8'd0}; end
        OP_SHLL16: begin we = 1'b1; wval = {rn[15:0], 16'd0}; end
        OP_SHLR8:  begin we = 1'b1; wval = {8'd0, rn[31:8]}; end
        OP_SHLR16: begin we = 1'b1; wval = {16'd0, rn[31:16]}; end
        OP_DT:     begin we = 1'b1; wval = rn - 32'd1; t_nxt = (rn == 32'd1); end
        OP_MOVT:   begin we = 1'b1; wval = {31'd0, t_r}; end
        default:   begin st = 1'b1; adv = 1'b0; end
      endcase
    end
  end

  logic [31:0] pc_nxt;
  always_comb begin
    pc_nxt = pc_r;
    if (adv) pc_nxt = pc_r + PcStep;
    else if (!q_cmd.mode && q_cmd.known &&
             ((q_cmd.opcode == 6'(OP_BTS)) || (q_cmd.opcode == 6'(OP_BFS))))
      pc_nxt = q_cmd.branch_target;
  end

  assign out_valid = ov_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r.status         <= st;
      res_r.next_pc        <= pc_nxt;
      res_r.t_flag         <= t_nxt;
      res_r.mem_kind       <= kind;
      res_r.mem_size       <= (kind == KindNone) ? SizeByte : size;
      res_r.mem_address    <= addr;
      res_r.mem_write_data <= wdata;
    end
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) rf_r[i] <= '0;
      pc_r <= start_pc;
      t_r  <= 1'b0;
      lp_r <= 1'b0;
      ld_r <= '0;
      lw_r <= SizeByte;
      ov_r <= 1'b0;
    end else begin
      if (fire) begin
        if (we) rf_r[wi] <= wval;
        pc_r <= pc_nxt;
        t_r  <= t_nxt;
        if (lset) begin
          lp_r <= 1'b1; ld_r <= ld_nxt; lw_r <= lw_nxt;
        end else if (q_cmd.mode) begin
          lp_r <= 1'b0;
        end
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/sh2_extended_instruction_execute_core.sv @@
`default_nettype none
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | mode, opcode, reg_n, reg_m, displacement, ...
// out     | output    | out_valid/out_ready  | status, next_pc, t_flag, mem_* fields
// cfg     | input     | cfg_valid/cfg_ready  | start_pc write data
// One word per cycle sustained while out is not stalled; each word passes a queue
// slot, then execute with a registered result.
// Reset loads the PC from the start_pc register and clears registers and T.
// A two-word queue decouples intake from execute; out stalls back up into it.
module sh2_extended_instruction_execute_core #(
  parameter int unsigned NUM_REGS = sh2x_pkg::NumRegs
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_start_pc,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [5:0]  in_opcode,
  input  wire logic [3:0]  in_reg_n,
  input  wire logic [3:0]  in_reg_m,
  input  wire logic [7:0]  in_displacement,
  input  wire logic [31:0] in_branch_target,
  input  wire logic [31:0] in_load_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_status,
  output logic [31:0]      out_next_pc,
  output logic             out_t_flag,
  output logic [1:0]       out_mem_kind,
  output logic [1:0]       out_mem_size,
  output logic [31:0]      out_mem_address,
  output logic [31:0]      out_mem_write_data
);
  import sh2x_pkg::*;

  logic [31:0] start_pc_r;
  logic        q_valid, q_ready;
  cmd_t        q_cmd;
  res_t        res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) start_pc_r <= '0;
    else if (cfg_valid) start_pc_r <= cfg_start_pc;
  end

  sh2x_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_opcode, .in_reg_n, .in_reg_m,
    .in_displacement, .in_branch_target, .in_load_data, .q_valid, .q_ready, .q_cmd
  );

  sh2x_back #(.NUM_REGS(NUM_REGS)) u_back (
    .clk, .rst_n, .start_pc(start_pc_r), .q_valid, .q_ready, .q_cmd,
    .out_valid, .out_ready, .out_res(res)
  );

  assign out_status         = res.status;
  assign out_next_pc        = res.next_pc;
  assign out_t_flag         = res.t_flag;
  assign out_mem_kind       = res.mem_kind;
  assign out_mem_size       = res.mem_size;
  assign out_mem_address    = res.mem_address;
  assign out_mem_write_data = res.mem_write_data;
endmodule
`default_nettype wire
